// ===== design/pfr_pkg.sv =====
// shared types, codes and constants of the page frame replacement store
`default_nettype none

package pfr_pkg;

	localparam int MAX_FRAMES_DEF = 512;
	localparam int PAGE_BITS_DEF  = 20;

	localparam int FRAMES_W   = 10;
	localparam int VICTIM_W   = 20;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;

	localparam logic [FRAMES_W-1:0] FRAMES_RESET = 10'd64;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic POL_FIFO = 1'b0;
	localparam logic POL_LRU  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_SCAN,
		ST_UPD
	} state_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic load;
		logic scan;
		logic wr;
		logic shift_all;
		logic use_prefix;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/page_frame_replacement_fifo_lru.sv =====
// top level: fully associative page frame store with FIFO or LRU replacement
//
// Command channel: an item (op, page_number) is taken at a rising edge with start high
// and busy low. op clear empties the store and zeroes both counters; op access looks
// the page up in a row of MAX_FRAMES cells ordered oldest (cell 0) to newest.
// Result: done is high for one cycle with hit, victim_valid, victim_page, hit_total
// and miss_total; the receiver cannot stall it and must take it in that cycle.
// Sequence: a clear gives its result in the cycle after it is taken and busy stays
// low, so one clear per cycle is possible. An access runs through a compare step
// in every cell, clog2(MAX_FRAMES) passes of the prefix-or that marks the cells at
// and above the hit, an update step in which cells shift toward the oldest end
// and the new page is written as the policy and the hit require, then the result
// cycle, during which the next item may already be taken.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data, cfg_ready always high;
// index 0 policy_mode, index 1 frames_in_use; to be written only while the block is idle (user's rule, not enforced).
// Reset: empty store, counters zero, FIFO policy, a limit of 64 frames.
`default_nettype none

module page_frame_replacement_fifo_lru #(
	parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = pfr_pkg::PAGE_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire                             op,
	input  wire  [PAGE_BITS-1:0]            page_number,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [pfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [pfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            done,
	output logic                            hit,
	output logic                            victim_valid,
	output logic [pfr_pkg::VICTIM_W-1:0]    victim_page,
	output logic [pfr_pkg::CNT_W-1:0]       hit_total,
	output logic [pfr_pkg::CNT_W-1:0]       miss_total
);
	import pfr_pkg::*;

	localparam int IDX_W  = $clog2(MAX_FRAMES);
	localparam int OCC_W  = $clog2(MAX_FRAMES + 1);
	localparam int LOG    = $clog2(MAX_FRAMES);
	localparam int STEP_W = (LOG > 1) ? $clog2(LOG) : 1;

	cell_ctl_t             ctl;
	logic [PAGE_BITS-1:0]  page_q;
	logic [OCC_W-1:0]      occ_q;
	logic [IDX_W-1:0]      tgt;
	logic [STEP_W-1:0]     step_q;
	logic [PAGE_BITS-1:0]  pages [MAX_FRAMES];
	logic                  prefix [MAX_FRAMES];
	logic [LOG-1:0]        cand [MAX_FRAMES];

	pfr_ctrl #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.IDX_W      (IDX_W),
		.OCC_W      (OCC_W),
		.LOG        (LOG),
		.STEP_W     (STEP_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.page_number  (page_number),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.prefix_last  (prefix[MAX_FRAMES-1]),
		.head_page    (pages[0]),
		.ctl          (ctl),
		.page_q       (page_q),
		.occ_q        (occ_q),
		.tgt          (tgt),
		.step_q       (step_q),
		.done         (done),
		.hit          (hit),
		.victim_valid (victim_valid),
		.victim_page  (victim_page),
		.hit_total    (hit_total),
		.miss_total   (miss_total)
	);

	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		logic [PAGE_BITS-1:0] nxt;

		// prefix-or pass k pulls the flag from the cell 2**k places older
		for (genvar k = 0; k < LOG; k++) begin : g_cand
			if (i >= (1 << k)) begin : g_tap
				assign cand[i][k] = prefix[i - (1 << k)];
			end else begin : g_edge
				assign cand[i][k] = 1'b0;
			end
		end

		if (i < MAX_FRAMES - 1) begin : g_mid
			assign nxt = pages[i + 1];
		end else begin : g_top
			assign nxt = pages[i];
		end

		pfr_cell #(
			.PAGE_BITS (PAGE_BITS),
			.IDX_W     (IDX_W),
			.OCC_W     (OCC_W),
			.INDEX     (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.page_in    (page_q),
			.next_page  (nxt),
			.occ        (occ_q),
			.tgt        (tgt),
			.prefix_in  (cand[i][step_q]),
			.page_out   (pages[i]),
			.prefix_out (prefix[i])
		);
	end

endmodule

`default_nettype wire

// ===== design/pfr_cell.sv =====
// one frame cell: resident page, match/prefix flag, shift from its newer neighbor
`default_nettype none

module pfr_cell #(
	parameter int PAGE_BITS = 20,
	parameter int IDX_W     = 9,
	parameter int OCC_W     = 10,
	parameter int INDEX     = 0
) (
	input  wire                   clk,
	input  pfr_pkg::cell_ctl_t    ctl,
	input  wire  [PAGE_BITS-1:0]  page_in,
	input  wire  [PAGE_BITS-1:0]  next_page,
	input  wire  [OCC_W-1:0]      occ,
	input  wire  [IDX_W-1:0]      tgt,
	input  wire                   prefix_in,
	output logic [PAGE_BITS-1:0]  page_out,
	output logic                  prefix_out
);
	import pfr_pkg::*;

	logic [PAGE_BITS-1:0] page_q;
	logic                 prefix_q;
	logic                 in_use;

	assign in_use = OCC_W'(INDEX) < occ;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prefix_q <= in_use && (page_q == page_in);
		end else if (ctl.scan) begin
			prefix_q <= prefix_q | prefix_in;
		end
	end

	// write of the new page wins over the shift toward the oldest end
	always_ff @(posedge clk) begin
		if (ctl.wr && (tgt == IDX_W'(INDEX))) begin
			page_q <= page_in;
		end else if (ctl.shift_all || (ctl.use_prefix && prefix_q)) begin
			page_q <= next_page;
		end
	end

	assign page_out   = page_q;
	assign prefix_out = prefix_q;

endmodule

`default_nettype wire

// ===== design/pfr_ctrl.sv =====
// sequencer, configuration registers, occupancy and hit/miss counters
`default_nettype none

module pfr_ctrl #(
	parameter int MAX_FRAMES = 512,
	parameter int PAGE_BITS  = 20,
	parameter int IDX_W      = 9,
	parameter int OCC_W      = 10,
	parameter int LOG        = 9,
	parameter int STEP_W     = 4
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	output logic                            busy,
	input  wire                             op,
	input  wire  [PAGE_BITS-1:0]            page_number,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [pfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [pfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             prefix_last,
	input  wire  [PAGE_BITS-1:0]            head_page,
	output pfr_pkg::cell_ctl_t              ctl,
	output logic [PAGE_BITS-1:0]            page_q,
	output logic [OCC_W-1:0]                occ_q,
	output logic [IDX_W-1:0]                tgt,
	output logic [STEP_W-1:0]               step_q,
	output logic                            done,
	output logic                            hit,
	output logic                            victim_valid,
	output logic [pfr_pkg::VICTIM_W-1:0]    victim_page,
	output logic [pfr_pkg::CNT_W-1:0]       hit_total,
	output logic [pfr_pkg::CNT_W-1:0]       miss_total
);
	import pfr_pkg::*;

	localparam int CW = (OCC_W > FRAMES_W) ? OCC_W : FRAMES_W;

	state_t               st_q, st_d;
	logic                 policy_q;
	logic [FRAMES_W-1:0]  frames_q;
	logic [FRAMES_W-1:0]  frames_eff;
	logic [CNT_W-1:0]     hit_cnt_q, miss_cnt_q;
	logic                 done_q, hit_q, vv_q;
	logic [VICTIM_W-1:0]  victim_q;
	logic                 accept, do_clear, do_access, evict, upd;
	logic [PAGE_BITS+VICTIM_W-1:0] head_ext;

	assign accept    = start && (st_q == ST_IDLE);
	assign do_clear  = accept && (op == OP_CLEAR);
	assign do_access = accept && (op == OP_ACCESS);
	assign upd       = (st_q == ST_UPD);
	assign busy      = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// a limit of zero acts as one, anything past the store acts as full
	assign frames_eff = (frames_q == '0) ? FRAMES_W'(1) : frames_q;
	assign evict = (CW'(occ_q) >= CW'(frames_eff)) || (occ_q == OCC_W'(MAX_FRAMES));
	assign head_ext = {{VICTIM_W{1'b0}}, head_page};

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (do_access) st_d = ST_CMP;
			ST_CMP:  st_d = ST_SCAN;
			ST_SCAN: if (step_q == STEP_W'(LOG - 1)) st_d = ST_UPD;
			ST_UPD:  st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.load       = (st_q == ST_CMP);
		ctl.scan       = (st_q == ST_SCAN);
		ctl.wr         = upd && (!prefix_last || (policy_q == POL_LRU));
		ctl.shift_all  = upd && !prefix_last && evict;
		ctl.use_prefix = upd && prefix_last && (policy_q == POL_LRU);
		if (prefix_last || evict) begin
			tgt = IDX_W'(occ_q - OCC_W'(1));
		end else begin
			tgt = IDX_W'(occ_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			step_q     <= '0;
			occ_q      <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			policy_q   <= POL_FIFO;
			frames_q   <= FRAMES_RESET;
			done_q     <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= do_clear || upd;
			if (st_q == ST_SCAN) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (do_clear) begin
				occ_q      <= '0;
				hit_cnt_q  <= '0;
				miss_cnt_q <= '0;
			end else if (upd) begin
				if (prefix_last) begin
					if (hit_cnt_q != '1) hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				end else begin
					if (miss_cnt_q != '1) miss_cnt_q <= miss_cnt_q + CNT_W'(1);
					if (!evict) occ_q <= occ_q + OCC_W'(1);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POLICY: policy_q <= cfg_data[0];
					REG_FRAMES: frames_q <= cfg_data[FRAMES_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page_number;
		end
		if (do_clear) begin
			hit_q    <= 1'b0;
			vv_q     <= 1'b0;
			victim_q <= '0;
		end else if (upd) begin
			hit_q    <= prefix_last;
			vv_q     <= !prefix_last && evict;
			victim_q <= (!prefix_last && evict) ? head_ext[VICTIM_W-1:0] : '0;
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign victim_valid = vv_q;
	assign victim_page  = victim_q;
	assign hit_total    = hit_cnt_q;
	assign miss_total   = miss_cnt_q;

`ifndef NO_ASSERTIONS
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(st_q) == ST_UPD) || $past(start && !busy && op == OP_CLEAR))
		else $error("result strobe without a finished item");
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(MAX_FRAMES))
		else $error("occupancy past the store depth");
	a_hit_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !victim_valid && (hit_total != '0))
		else $error("hit result with a victim or zero hit count");
	a_victim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !victim_valid |-> victim_page == '0)
		else $error("victim page set without an eviction");
	a_busy_window: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == OP_ACCESS |=> busy ##1 busy)
		else $error("access finished too early");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_page_frame_replacement_fifo_lru.sv =====
`timescale 1ns / 100ps
// self-checking bench for the fifo/lru page frame store: directed and random access streams
module tb_page_frame_replacement_fifo_lru;
	import pfr_pkg::*;

	localparam int PAGE_W        = PAGE_BITS_DEF;
	localparam int ACCESS_CYCLES = 3 + $clog2(MAX_FRAMES_DEF);
	localparam int SETTLE_CYCLES = ACCESS_CYCLES + 4;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 40;

	typedef logic [PAGE_W-1:0] page_t;

	typedef struct packed {
		logic                hit;
		logic                victim_valid;
		logic [VICTIM_W-1:0] victim_page;
		logic [CNT_W-1:0]    hit_total;
		logic [CNT_W-1:0]    miss_total;
	} lookup_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  op;
	page_t                 page_number;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  done;
	logic                  hit;
	logic                  victim_valid;
	logic [VICTIM_W-1:0]   victim_page;
	logic [CNT_W-1:0]      hit_total;
	logic [CNT_W-1:0]      miss_total;

	// shadow copy of the store and its registers
	page_t               resident[$];
	logic                policy_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [CNT_W-1:0]    hits_q;
	logic [CNT_W-1:0]    misses_q;

	lookup_t pending_lookups[$];
	int      error_count;
	int      quiet_cycles;
	bit      no_gaps;

	page_frame_replacement_fifo_lru dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.page_number  (page_number),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.hit          (hit),
		.victim_valid (victim_valid),
		.victim_page  (victim_page),
		.hit_total    (hit_total),
		.miss_total   (miss_total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic lookup_t model_page_access(logic op_v, page_t pg);
		lookup_t r;
		int      lim;
		int      pos;
		r   = '0;
		pos = -1;
		if (op_v == OP_CLEAR) begin
			resident.delete();
			hits_q   = '0;
			misses_q = '0;
		end else begin
			if (frames_q == '0)
				lim = 1;
			else if (int'(frames_q) > MAX_FRAMES_DEF)
				lim = MAX_FRAMES_DEF;
			else
				lim = int'(frames_q);
			foreach (resident[i])
				if (pos < 0 && resident[i] == pg)
					pos = i;
			if (pos >= 0) begin
				r.hit = 1'b1;
				if (hits_q != '1)
					hits_q = hits_q + CNT_W'(1);
				if (policy_q == POL_LRU) begin
					resident.delete(pos);
					resident = {resident, pg};
				end
			end else begin
				if (misses_q != '1)
					misses_q = misses_q + CNT_W'(1);
				// only the single oldest page goes, even when the limit was lowered
				if (resident.size() + 1 > lim && resident.size() > 0) begin
					r.victim_valid = 1'b1;
					r.victim_page  = resident[0];
					resident.delete(0);
				end
				if (resident.size() < MAX_FRAMES_DEF)
					resident = {resident, pg};
			end
		end
		r.hit_total  = hits_q;
		r.miss_total = misses_q;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	task automatic send_item(logic op_v, page_t pg);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		op          <= op_v;
		page_number <= pg;
		do @(posedge clk); while (busy);
		pending_lookups = {pending_lookups, model_page_access(op_v, pg)};
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_lookups.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// two config beats back to back, valid held high between them
	task automatic configure(logic pol, logic [FRAMES_W-1:0] frames);
		logic [CFG_DATA_W-1:0] pol_word;
		wait_idle();
		pol_word    = CFG_DATA_W'($urandom());
		pol_word[0] = pol;
		cfg_valid <= 1'b1;
		cfg_index <= REG_POLICY;
		cfg_data  <= pol_word;
		do @(posedge clk); while (!cfg_ready);
		policy_q = pol;
		cfg_index <= REG_FRAMES;
		cfg_data  <= frames;
		do @(posedge clk); while (!cfg_ready);
		frames_q = frames;
		cfg_valid <= 1'b0;
	endtask

	// reset values: fifo, 64 frames; the 65th distinct page evicts the first
	task automatic test_reset_defaults();
		send_item(OP_ACCESS, 20'h00000);
		send_item(OP_ACCESS, 20'hFFFFF);
		send_item(OP_ACCESS, 20'h00000);
		for (int i = 0; i < 63; i++)
			send_item(OP_ACCESS, page_t'(20'h10000 + i));
		send_item(OP_ACCESS, 20'h00000);
		send_item(OP_ACCESS, 20'hFFFFF);
		send_item(OP_CLEAR, 20'hFFFFF);
		send_item(OP_ACCESS, 20'hFFFFF);
		send_item(OP_CLEAR, 20'h00000);
	endtask

	task automatic test_replacement_policies();
		configure(POL_FIFO, 10'd2);
		send_item(OP_CLEAR, 20'h0);
		send_item(OP_ACCESS, 20'h0000A);
		send_item(OP_ACCESS, 20'h0000B);
		send_item(OP_ACCESS, 20'h0000A);
		send_item(OP_ACCESS, 20'h0000C);
		send_item(OP_ACCESS, 20'h0000A);
		configure(POL_LRU, 10'd2);
		send_item(OP_CLEAR, 20'h0);
		send_item(OP_ACCESS, 20'h0000A);
		send_item(OP_ACCESS, 20'h0000B);
		send_item(OP_ACCESS, 20'h0000A);
		send_item(OP_ACCESS, 20'h0000C);
		send_item(OP_ACCESS, 20'h0000B);
	endtask

	// a limit of zero behaves as one frame
	task automatic test_zero_limit();
		configure(POL_FIFO, 10'd0);
		send_item(OP_CLEAR, 20'h0);
		send_item(OP_ACCESS, 20'h55555);
		send_item(OP_ACCESS, 20'hAAAAA);
		send_item(OP_ACCESS, 20'hAAAAA);
	endtask

	task automatic test_limit_lowered();
		configure(POL_LRU, 10'd16);
		send_item(OP_CLEAR, 20'h0);
		for (int i = 0; i < 8; i++)
			send_item(OP_ACCESS, page_t'(20'h300 + i));
		configure(POL_LRU, 10'd3);
		send_item(OP_ACCESS, 20'h400);
		send_item(OP_ACCESS, 20'h305);
		send_item(OP_ACCESS, 20'h401);
		send_item(OP_ACCESS, 20'h307);
	endtask

	// fill every frame: a limit above the store size acts as the full store
	task automatic test_full_store();
		page_t base;
		base = page_t'($urandom());
		configure(POL_LRU, 10'd1023);
		send_item(OP_CLEAR, 20'h0);
		for (int i = 0; i < MAX_FRAMES_DEF + 2; i++)
			send_item(OP_ACCESS, base ^ page_t'(i));
		send_item(OP_ACCESS, base ^ page_t'(5));
		configure(POL_FIFO, 10'd512);
		send_item(OP_ACCESS, ~base);
		send_item(OP_ACCESS, base ^ page_t'(3));
	endtask

	task automatic test_random_streams();
		page_t               hot[16];
		int                  hot_n;
		int                  phase_len;
		int                  sent;
		int                  r;
		logic [FRAMES_W-1:0] frames;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: frames = FRAMES_W'($urandom_range(1, 8));
				4, 5, 6:    frames = FRAMES_W'($urandom_range(9, 32));
				7:          frames = '0;
				8:          frames = FRAMES_W'($urandom_range(33, 1023));
				default: begin
					case ($urandom_range(0, 3))
						0:       frames = 10'd1;
						1:       frames = FRAMES_RESET;
						2:       frames = 10'd512;
						default: frames = 10'd1023;
					endcase
				end
			endcase
			// config changes without a clear leave old pages resident
			configure(logic'($urandom_range(0, 1)), frames);
			hot_n = $urandom_range(2, 16);
			for (int i = 0; i < 16; i++)
				hot[i] = page_t'($urandom());
			no_gaps   = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 60);
			if ($urandom_range(0, 1) == 0)
				send_item(OP_CLEAR, page_t'($urandom()));
			for (int k = 0; k < phase_len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 3)
					send_item(OP_CLEAR, page_t'($urandom()));
				else if (r < 83)
					send_item(OP_ACCESS, hot[$urandom_range(0, hot_n - 1)]);
				else
					send_item(OP_ACCESS, page_t'($urandom()));
				sent++;
			end
		end
		no_gaps = 1'b0;
	endtask

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && done) begin
			if (pending_lookups.size() == 0) begin
				$error("result beat with no access waiting");
				error_count++;
			end else begin
				want = pending_lookups[0];
				pending_lookups.delete(0);
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					error_count++;
				end
				if (victim_valid !== want.victim_valid) begin
					$error("victim_valid: expected %0d, got %0d",
						want.victim_valid, victim_valid);
					error_count++;
				end
				if (victim_page !== want.victim_page) begin
					$error("victim_page: expected %h, got %h", want.victim_page, victim_page);
					error_count++;
				end
				if (hit_total !== want.hit_total) begin
					$error("hit_total: expected %0d, got %0d", want.hit_total, hit_total);
					error_count++;
				end
				if (miss_total !== want.miss_total) begin
					$error("miss_total: expected %0d, got %0d", want.miss_total, miss_total);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		op          <= OP_ACCESS;
		page_number <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_POLICY;
		cfg_data    <= '0;
		quiet_cycles = 0;
		error_count  = 0;
		no_gaps      = 1'b0;
		policy_q     = POL_FIFO;
		frames_q     = FRAMES_RESET;
		hits_q       = '0;
		misses_q     = '0;
		resident.delete();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_replacement_policies();
		test_zero_limit();
		test_limit_lowered();
		test_full_store();
		test_random_streams();
		wait_idle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
